>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle check failed.");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle check failed.");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/art_pkg.sv
// ----------------------------------------------------------------------------
// AES round transform package
// Sizes, codes, control structs and byte-level GF(2^8) helpers.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int MAX_COLUMNS   = 8;
   localparam int MIN_COLUMNS   = 4;
   localparam int RESET_COLUMNS = 4;
   localparam int COL_IDX_W     = $clog2(MAX_COLUMNS);
   localparam int COUNT_W       = $clog2(MAX_COLUMNS + 1);
   localparam int WORD_W        = 32;
   localparam int KIND_W        = 3;
   localparam int CFG_COLUMNS_W = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 4;

   localparam logic [7:0] GF_POLY = 8'h1b;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD        = 3'd0,
      KIND_ADD_KEY     = 3'd1,
      KIND_SUB_BYTES   = 3'd2,
      KIND_SHIFT_ROWS  = 3'd3,
      KIND_MIX_COLUMNS = 3'd4,
      KIND_READ_OUT    = 3'd5
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BLOCK_COLUMNS = 1'b0,
      CSR_DECRYPT_MODE  = 1'b1
   } csr_index_type;

   typedef logic [MAX_COLUMNS-1:0][WORD_W-1:0] state_type;

   typedef struct packed {
      logic mix;
      logic inv;
   } lane_ctrl_type;

   typedef struct packed {
      kind_type              op;
      logic                  inv;
      logic [COUNT_W-1:0]    active;
      logic [COL_IDX_W-1:0]  index;
      logic [WORD_W-1:0]     word;
   } merge_ctrl_type;

   localparam logic [2047:0] SBOX_FWD_BITS = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   localparam logic [2047:0] SBOX_INV_BITS = {
      128'h52096ad53036a538bf40a39e81f3d7fb,
      128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e,
      128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692,
      128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506,
      128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673,
      128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b,
      128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f,
      128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961,
      128'h172b047eba77d626e169146355210c7d
   };

   function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
      return SBOX_FWD_BITS[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] sbox_inv(input logic [7:0] x);
      return SBOX_INV_BITS[{~x, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
   endfunction

endpackage

>>> sv/art_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one command item per transfer.
// ----------------------------------------------------------------------------
interface art_req_if import art_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [COL_IDX_W-1:0]  column_index;
   logic [WORD_W-1:0]     column_word;

   modport source (output valid, kind, column_index, column_word, input ready);
   modport sink (input valid, kind, column_index, column_word, output ready);

endinterface

>>> sv/art_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one read-out column per transfer.
// ----------------------------------------------------------------------------
interface art_rsp_if import art_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [WORD_W-1:0]     out_column;
   logic [COL_IDX_W-1:0]  out_index;
   logic                  out_last;

   modport source (output valid, out_column, out_index, out_last, input ready);
   modport sink (input valid, out_column, out_index, out_last, output ready);

endinterface

>>> sv/art_lane.sv
// ----------------------------------------------------------------------------
// Column lane
// SubBytes and MixColumns, forward or inverse, on one state column.
// ----------------------------------------------------------------------------
module art_lane import art_pkg::*; (
   input  logic [WORD_W-1:0] col_in,
   input  lane_ctrl_type     ctrl,
   output logic [WORD_W-1:0] col_out
);

   logic [7:0]        b    [4];
   logic [7:0]        x2   [4];
   logic [7:0]        x4   [4];
   logic [7:0]        x8   [4];
   logic [7:0]        prod [4][4];
   logic [WORD_W-1:0] sub_word;
   logic [WORD_W-1:0] mix_word;

   always_comb begin
      logic [7:0] acc;
      logic [1:0] k;
      acc = 8'h00;
      k = 2'd0;
      for (int j = 0; j < 4; j++) begin
         b[j] = col_in[8*j +: 8];
         x2[j] = xtime(b[j]);
         x4[j] = xtime(x2[j]);
         x8[j] = xtime(x4[j]);
         sub_word[8*j +: 8] = ctrl.inv ? sbox_inv(b[j]) : sbox_fwd(b[j]);
         if (ctrl.inv) begin
            prod[j][0] = x8[j] ^ x4[j] ^ x2[j];
            prod[j][1] = x8[j] ^ x2[j] ^ b[j];
            prod[j][2] = x8[j] ^ x4[j] ^ b[j];
            prod[j][3] = x8[j] ^ b[j];
         end else begin
            prod[j][0] = x2[j];
            prod[j][1] = x2[j] ^ b[j];
            prod[j][2] = b[j];
            prod[j][3] = b[j];
         end
      end
      for (int r = 0; r < 4; r++) begin
         acc = 8'h00;
         for (int j = 0; j < 4; j++) begin
            k = 2'(j - r);
            acc = acc ^ prod[j][k];
         end
         mix_word[8*r +: 8] = acc;
      end
   end

   assign col_out = ctrl.mix ? mix_word : sub_word;

endmodule

>>> sv/art_merge.sv
// ----------------------------------------------------------------------------
// State merge
// Combines lane results, row rotation and column writes into the next state.
// ----------------------------------------------------------------------------
module art_merge import art_pkg::*; (
   input  state_type      state_cur,
   input  state_type      lane_out,
   input  merge_ctrl_type ctrl,
   output state_type      state_next
);

   logic index_ok;

   assign index_ok = COUNT_W'(ctrl.index) < ctrl.active;

   always_comb begin
      logic [COUNT_W-1:0] sum;
      logic [COUNT_W-1:0] src;
      sum = '0;
      src = '0;
      state_next = state_cur;
      case (ctrl.op)
         KIND_LOAD: begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               if (index_ok && COL_IDX_W'(c) == ctrl.index) begin
                  state_next[c] = ctrl.word;
               end
            end
         end
         KIND_ADD_KEY: begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               if (index_ok && COL_IDX_W'(c) == ctrl.index) begin
                  state_next[c] = state_cur[c] ^ ctrl.word;
               end
            end
         end
         KIND_SUB_BYTES, KIND_MIX_COLUMNS: begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               if (COUNT_W'(c) < ctrl.active) begin
                  state_next[c] = lane_out[c];
               end
            end
         end
         KIND_SHIFT_ROWS: begin
            for (int c = 0; c < MAX_COLUMNS; c++) begin
               for (int r = 1; r < 4; r++) begin
                  if (COUNT_W'(c) < ctrl.active) begin
                     if (ctrl.inv) begin
                        if (c >= r) begin
                           src = COUNT_W'(c - r);
                        end else begin
                           src = COUNT_W'(c) + ctrl.active - COUNT_W'(r);
                        end
                     end else begin
                        sum = COUNT_W'(c) + COUNT_W'(r);
                        src = (sum >= ctrl.active) ? sum - ctrl.active : sum;
                     end
                     state_next[c][8*r +: 8] = state_cur[src[COL_IDX_W-1:0]][8*r +: 8];
                  end
               end
            end
         end
         default: begin
            state_next = state_cur;
         end
      endcase
   end

endmodule

>>> sv/aes_round_transform_unit.sv
// ----------------------------------------------------------------------------
// AES round transform unit
// Load, add key, sub bytes, shift rows and mix columns each update the state
// register on their transfer; the request side stays ready after them.
// A read out emits one column per cycle from the output register while the
// response side is ready; requests wait until the last column is loaded.
// Synchronous reset clears control state and sets four columns, forward mode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aes_round_transform_unit import art_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   art_req_if.sink                req_chan,
   art_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_READ
   } fsm_type;

   fsm_type                    fsm_ff;
   logic [CFG_COLUMNS_W-1:0]   block_columns_ff;
   logic                       decrypt_mode_ff;
   state_type                  state_ff;
   state_type                  state_in;
   state_type                  lane_out;
   state_type                  merged;
   lane_ctrl_type              lane_ctrl;
   merge_ctrl_type             merge_ctrl;
   logic [COUNT_W-1:0]         active;
   logic [COL_IDX_W-1:0]       last_index;
   logic [COL_IDX_W-1:0]       cnt_ff;
   logic                       is_last;
   logic                       req_transfer;
   logic                       rsp_load;
   logic                       rsp_valid_ff;
   logic [WORD_W-1:0]          rsp_column_ff;
   logic [COL_IDX_W-1:0]       rsp_index_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_columns_ff <= CFG_COLUMNS_W'(RESET_COLUMNS);
         decrypt_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCK_COLUMNS: begin
               block_columns_ff <= csr_wr_data[CFG_COLUMNS_W-1:0];
            end
            CSR_DECRYPT_MODE: begin
               decrypt_mode_ff <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign active = (block_columns_ff < CFG_COLUMNS_W'(MIN_COLUMNS)) ? COUNT_W'(MIN_COLUMNS) :
                   (block_columns_ff > CFG_COLUMNS_W'(MAX_COLUMNS)) ? COUNT_W'(MAX_COLUMNS) :
                   COUNT_W'(block_columns_ff);
   assign last_index = COL_IDX_W'(active - COUNT_W'(1));
   assign is_last = cnt_ff == last_index;

   assign req_chan.ready = fsm_ff == ST_IDLE;
   assign req_transfer = req_chan.valid && req_chan.ready;

   assign lane_ctrl.mix = req_chan.kind == KIND_MIX_COLUMNS;
   assign lane_ctrl.inv = decrypt_mode_ff;

   for (genvar g = 0; g < MAX_COLUMNS; g++) begin : g_lane
      art_lane u_lane (
         .col_in  (state_ff[g]),
         .ctrl    (lane_ctrl),
         .col_out (lane_out[g])
      );
   end

   assign merge_ctrl.op = kind_type'(req_chan.kind);
   assign merge_ctrl.inv = decrypt_mode_ff;
   assign merge_ctrl.active = active;
   assign merge_ctrl.index = req_chan.column_index;
   assign merge_ctrl.word = req_chan.column_word;

   art_merge u_merge (
      .state_cur  (state_ff),
      .lane_out   (lane_out),
      .ctrl       (merge_ctrl),
      .state_next (merged)
   );

   assign state_in = req_transfer ? merged : state_ff;

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign rsp_load = (fsm_ff == ST_READ) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (fsm_ff)
            ST_IDLE: begin
               if (req_transfer && req_chan.kind == KIND_READ_OUT) begin
                  fsm_ff <= ST_READ;
                  cnt_ff <= '0;
               end
            end
            ST_READ: begin
               if (rsp_load) begin
                  rsp_column_ff <= state_ff[cnt_ff];
                  rsp_index_ff <= cnt_ff;
                  rsp_last_ff <= is_last;
                  cnt_ff <= cnt_ff + COL_IDX_W'(1);
                  if (is_last) begin
                     fsm_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               fsm_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_column = rsp_column_ff;
   assign rsp_chan.out_index = rsp_index_ff;
   assign rsp_chan.out_last = rsp_last_ff;

   `ASSERT_IMPLY(a_last_on_final_column, clock, reset, rsp_chan.valid && rsp_chan.out_last, rsp_chan.out_index == last_index)
   `ASSERT_NEXT(a_read_out_blocks_requests, clock, reset, req_transfer && req_chan.kind == KIND_READ_OUT, !req_chan.ready)
   `ASSERT_NEXT(a_index_steps_by_one, clock, reset, rsp_chan.valid && rsp_chan.ready && !rsp_chan.out_last, rsp_chan.valid && rsp_chan.out_index == $past(rsp_chan.out_index) + COL_IDX_W'(1))

endmodule
